/* sv/atl_pkg.sv */
`timescale 1ns / 1ps

package atl_pkg;

    localparam logic [3:0] K_INVALID = 4'd0;
    localparam logic [3:0] K_EOF     = 4'd1;
    localparam logic [3:0] K_NEWLINE = 4'd2;
    localparam logic [3:0] K_SPEC    = 4'd3;
    localparam logic [3:0] K_LABEL   = 4'd4;
    localparam logic [3:0] K_IDENT   = 4'd5;
    localparam logic [3:0] K_NUMBER  = 4'd6;
    localparam logic [3:0] K_LITERAL = 4'd7;
    localparam logic [3:0] K_OPEN    = 4'd8;
    localparam logic [3:0] K_CLOSE   = 4'd9;
    localparam logic [3:0] K_TEXT    = 4'd10;

    // output queue: two slots must be free before a character is taken
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  text_char;
        logic [63:0] number_value;
        logic        overflow;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    beat1;
        t_result    beat0;
    } t_push;

endpackage

/* sv/atl_beat_fifo.sv */
`timescale 1ns / 1ps

module atl_beat_fifo
    import atl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_not_empty,
    output logic    o_room_for_two,
    output t_result o_head
);

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   w_pop;

    assign o_not_empty    = (r_count != '0);
    assign o_room_for_two = (r_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign o_head         = r_mem[r_rd_ptr];
    assign w_pop          = i_pop && o_not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_W'(w_pop);
        n_count  = r_count + QUEUE_CNT_W'(i_push.count) - QUEUE_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.beat0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + QUEUE_PTR_W'(1)] <= i_push.beat1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* sv/assembly_token_lexer.sv */
`timescale 1ns / 1ps
// Streaming lexer for a high-level assembler.
// Slave side: one source character per beat. tdata carries the byte, tuser
// flags end of text (byte then ignored; each such beat answers with eof).
// Master side: token beats. tuser is the token kind, tdata carries text
// char, value, overflow, line and column, tlast closes the results of one
// input beat. A character gives zero, one or two token beats.
// The token beats of a character are written into the output queue when its
// beat is taken. The scanner accepts one character every cycle while the
// four-beat output queue has two free slots; sustained rate is one
// character per cycle when characters give at most one token each, bounded
// by the single master beat per cycle otherwise.
// Stall: when the receiver holds tready low the queue fills and s_tready
// drops until two slots free again; nothing is lost.
// Reset (synchronous, active low): scanner back to idle, no pending token,
// line and column zero, output queue empty.
module assembly_token_lexer
    import atl_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,   // [7:0] ch
    input  logic          i_s_tuser,   // [0] end_of_text
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [111:0]  o_m_tdata,   // [7:0] text_char, [71:8] number_value,
                                       // [72] overflow, [88:73] token_line,
                                       // [104:89] token_column, rest zero
    output logic [3:0]    o_m_tuser,   // [3:0] kind
    output logic          o_m_tlast
);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NLSEEN  = 3'd1;
    localparam logic [2:0] M_COMMENT = 3'd2;
    localparam logic [2:0] M_NUMBER  = 3'd3;
    localparam logic [2:0] M_LITERAL = 3'd4;
    localparam logic [2:0] M_IDENT   = 3'd5;
    localparam logic [2:0] M_SPEC    = 3'd6;

    localparam logic [1:0] P_NONE  = 2'd0;
    localparam logic [1:0] P_DOT   = 2'd1;
    localparam logic [1:0] P_POUND = 2'd2;
    localparam logic [1:0] P_IDENT = 2'd3;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_OPEN   = 8'd91;
    localparam logic [7:0] CH_CLOSE  = 8'd93;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_POUND  = 8'd35;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_ZERO   = 8'd48;

    localparam int LINE_EXT = (LINE_BITS > 16) ? LINE_BITS : 16;
    localparam int COL_EXT  = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

    logic [2:0]             r_mode;
    logic [1:0]             r_pend;
    logic [63:0]            r_acc;
    logic                   r_sat;
    logic [LINE_BITS-1:0]   r_pline;
    logic [COLUMN_BITS-1:0] r_pcol;
    logic [LINE_BITS-1:0]   r_line;
    logic [COLUMN_BITS-1:0] r_col;

    logic [2:0]             n_mode;
    logic [1:0]             n_pend;
    logic [63:0]            n_acc;
    logic                   n_sat;
    logic [LINE_BITS-1:0]   n_pline;
    logic [COLUMN_BITS-1:0] n_pcol;
    logic [LINE_BITS-1:0]   n_line;
    logic [COLUMN_BITS-1:0] n_col;

    t_result     n_res [2];
    logic [1:0]  n_cnt;
    logic        w_take;
    logic        w_room;
    logic        w_done;
    logic        w_eof;
    logic [7:0]  w_c;
    logic [67:0] w_mac;
    t_push       w_push;
    t_result     w_head;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'd9, 8'd11, 8'd12, 8'd32};
    endfunction

    function automatic logic is_nl(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'd48:8'd57]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'd65:8'd90], [8'd97:8'd122]};
    endfunction

    function automatic logic [15:0] clamp_line(input logic [LINE_BITS-1:0] v);
        logic [LINE_EXT-1:0] e;
        e = LINE_EXT'(v);
        return (e > LINE_EXT'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic logic [15:0] clamp_col(input logic [COLUMN_BITS-1:0] v);
        logic [COL_EXT-1:0] e;
        e = COL_EXT'(v);
        return (e > COL_EXT'(16'hFFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic t_result mk(input logic [3:0] kind, input logic [7:0] tc,
                                   input logic [63:0] val, input logic ovf,
                                   input logic [LINE_BITS-1:0] ln,
                                   input logic [COLUMN_BITS-1:0] cl);
        t_result r;
        r.kind         = kind;
        r.text_char    = tc;
        r.number_value = val;
        r.overflow     = ovf;
        r.token_line   = clamp_line(ln);
        r.token_column = clamp_col(cl);
        r.last         = 1'b0;
        return r;
    endfunction

    assign w_c    = i_s_tdata;
    assign w_eof  = i_s_tuser;
    assign w_take = i_s_tvalid && w_room;
    assign o_s_tready = w_room;

    // acc * 10 + digit; any carry above bit 63 means saturation
    assign w_mac = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                 + {64'd0, w_c[3:0] - CH_ZERO[3:0]};

    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_sat   = r_sat;
        n_pline = r_pline;
        n_pcol  = r_pcol;
        n_line  = r_line;
        n_col   = r_col;
        n_res[0] = '0;
        n_res[1] = '0;
        n_cnt   = 2'd0;
        w_done  = 1'b0;

        if (n_mode == M_NLSEEN) begin
            n_mode = M_IDLE;
            if (!w_eof && is_nl(w_c)) begin
                w_done = 1'b1;
            end
        end

        if (!w_done) begin
            if (!w_eof && (n_col != '1)) begin
                n_col = n_col + COLUMN_BITS'(1);
            end

            case (n_mode)
                M_COMMENT: begin
                    if (!w_eof && !is_nl(w_c)) begin
                        w_done = 1'b1;
                    end else begin
                        n_mode = M_IDLE;
                    end
                end
                M_NUMBER, M_LITERAL: begin
                    if (!w_eof && is_digit(w_c)) begin
                        if (w_mac[67:64] != 4'd0) begin
                            n_acc = '1;
                            n_sat = 1'b1;
                        end else begin
                            n_acc = w_mac[63:0];
                        end
                        w_done = 1'b1;
                    end else begin
                        n_res[n_cnt[0]] = mk((n_mode == M_NUMBER) ? K_NUMBER : K_LITERAL,
                                             8'd0, r_acc, r_sat, r_pline, r_pcol);
                        n_cnt  = n_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_IDENT, M_SPEC: begin
                    if (!w_eof && !is_blank(w_c) && !is_nl(w_c)) begin
                        n_res[n_cnt[0]] = mk(K_TEXT, w_c, 64'd0, 1'b0, n_line, n_col);
                        n_cnt  = n_cnt + 2'd1;
                        w_done = 1'b1;
                    end else begin
                        if (n_mode == M_IDENT) begin
                            n_pend = P_IDENT;
                        end else begin
                            n_res[n_cnt[0]] = mk(K_SPEC, 8'd0, 64'd0, 1'b0,
                                                 r_pline, r_pcol);
                            n_cnt = n_cnt + 2'd1;
                        end
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase
        end

        if (!w_done) begin
            if (w_eof || !is_blank(w_c)) begin
                if (!w_eof && (n_pend == P_IDENT) && (w_c == CH_COLON)) begin
                    n_res[n_cnt[0]] = mk(K_LABEL, 8'd0, 64'd0, 1'b0, r_pline, r_pcol);
                    n_cnt  = n_cnt + 2'd1;
                    n_pend = P_NONE;
                end else if (!w_eof && (n_pend == P_DOT) && is_alpha(w_c)) begin
                    n_pend = P_NONE;
                    n_mode = M_SPEC;
                    n_res[n_cnt[0]] = mk(K_TEXT, w_c, 64'd0, 1'b0, n_line, n_col);
                    n_cnt  = n_cnt + 2'd1;
                end else if (!w_eof && (n_pend == P_POUND) && is_digit(w_c)) begin
                    n_pend = P_NONE;
                    n_mode = M_LITERAL;
                    n_acc  = {60'd0, w_c[3:0] - CH_ZERO[3:0]};
                    n_sat  = 1'b0;
                end else begin
                    // flush whatever token still waits
                    case (n_pend)
                        P_DOT: begin
                            n_res[n_cnt[0]] = mk(K_INVALID, CH_DOT, 64'd0, 1'b0,
                                                 r_pline, r_pcol);
                            n_cnt = n_cnt + 2'd1;
                        end
                        P_POUND: begin
                            n_res[n_cnt[0]] = mk(K_INVALID, CH_POUND, 64'd0, 1'b0,
                                                 r_pline, r_pcol);
                            n_cnt = n_cnt + 2'd1;
                        end
                        P_IDENT: begin
                            n_res[n_cnt[0]] = mk(K_IDENT, 8'd0, 64'd0, 1'b0,
                                                 r_pline, r_pcol);
                            n_cnt = n_cnt + 2'd1;
                        end
                        default: begin
                        end
                    endcase
                    n_pend = P_NONE;

                    if (w_eof) begin
                        n_res[n_cnt[0]] = mk(K_EOF, 8'd0, 64'd0, 1'b0, n_line, n_col);
                        n_cnt = n_cnt + 2'd1;
                    end else if (is_nl(w_c)) begin
                        n_res[n_cnt[0]] = mk(K_NEWLINE, 8'd0, 64'd0, 1'b0, n_line, n_col);
                        n_cnt = n_cnt + 2'd1;
                        if (n_line != '1) begin
                            n_line = n_line + LINE_BITS'(1);
                        end
                        n_col  = '0;
                        n_mode = M_NLSEEN;
                    end else if (w_c == CH_OPEN) begin
                        n_res[n_cnt[0]] = mk(K_OPEN, 8'd0, 64'd0, 1'b0, n_line, n_col);
                        n_cnt = n_cnt + 2'd1;
                    end else if (w_c == CH_CLOSE) begin
                        n_res[n_cnt[0]] = mk(K_CLOSE, 8'd0, 64'd0, 1'b0, n_line, n_col);
                        n_cnt = n_cnt + 2'd1;
                    end else if ((w_c == CH_DOT) || (w_c == CH_POUND)) begin
                        n_pend  = (w_c == CH_DOT) ? P_DOT : P_POUND;
                        n_pline = n_line;
                        n_pcol  = n_col;
                    end else if (w_c == CH_SEMI) begin
                        n_mode = M_COMMENT;
                    end else if (is_digit(w_c)) begin
                        n_mode  = M_NUMBER;
                        n_acc   = {60'd0, w_c[3:0] - CH_ZERO[3:0]};
                        n_sat   = 1'b0;
                        n_pline = n_line;
                        n_pcol  = n_col;
                    end else if (is_alpha(w_c)) begin
                        n_mode  = M_IDENT;
                        n_pline = n_line;
                        n_pcol  = n_col;
                        n_res[n_cnt[0]] = mk(K_TEXT, w_c, 64'd0, 1'b0, n_line, n_col);
                        n_cnt = n_cnt + 2'd1;
                    end else begin
                        n_res[n_cnt[0]] = mk(K_INVALID, w_c, 64'd0, 1'b0, n_line, n_col);
                        n_cnt = n_cnt + 2'd1;
                    end
                end
            end
        end

        if (n_cnt == 2'd1) begin
            n_res[0].last = 1'b1;
        end else if (n_cnt == 2'd2) begin
            n_res[1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pend  <= P_NONE;
            r_acc   <= '0;
            r_sat   <= 1'b0;
            r_pline <= '0;
            r_pcol  <= '0;
            r_line  <= '0;
            r_col   <= '0;
        end else if (w_take) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_acc   <= n_acc;
            r_sat   <= n_sat;
            r_pline <= n_pline;
            r_pcol  <= n_pcol;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    always_comb begin
        w_push.count = w_take ? n_cnt : 2'd0;
        w_push.beat0 = n_res[0];
        w_push.beat1 = n_res[1];
    end

    atl_beat_fifo u_queue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (w_push),
        .i_pop          (i_m_tready),
        .o_not_empty    (o_m_tvalid),
        .o_room_for_two (w_room),
        .o_head         (w_head)
    );

    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;
    assign o_m_tdata = {7'd0, w_head.token_column, w_head.token_line,
                        w_head.overflow, w_head.number_value, w_head.text_char};

endmodule

/* test/lexer_token_checker.sv */
`timescale 1ns / 1ps

module lexer_token_checker
    import atl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] ch
    input  logic         i_s_tuser,   // [0] end_of_text
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [111:0] i_m_tdata,   // [7:0] text_char, [71:8] number_value,
                                      // [72] overflow, [88:73] token_line,
                                      // [104:89] token_column, rest zero
    input  logic [3:0]   i_m_tuser,   // [3:0] kind
    input  logic         i_m_tlast,
    output int           o_errors,
    output int           o_outstanding
);

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_OPEN  = "[";
    localparam logic [7:0] CH_CLOSE = "]";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_POUND = "#";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_ZERO  = "0";

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_NLSEEN, SCAN_COMMENT, SCAN_NUMBER,
        SCAN_LITERAL, SCAN_IDENT, SCAN_SPEC
    } t_scan;

    typedef enum logic [1:0] {HOLD_NONE, HOLD_DOT, HOLD_POUND, HOLD_IDENT} t_hold;

    t_scan       mode;
    t_hold       held;
    logic [63:0] acc;
    logic        saturated;
    logic [15:0] held_line;
    logic [15:0] held_col;
    logic [15:0] line_count;
    logic [15:0] col_count;

    t_result     step_tokens [3];
    int          step_count;
    t_result     expected_tokens [$];
    t_result     want;
    t_result     tok;
    int          mismatches;
    int          k;

    assign o_errors = mismatches;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd11 || c == 8'd12;
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    task automatic note(input logic [3:0] kind, input logic [7:0] tc,
                        input logic [63:0] val, input logic ovf,
                        input logic [15:0] line, input logic [15:0] col);
        step_tokens[step_count].kind         = kind;
        step_tokens[step_count].text_char    = tc;
        step_tokens[step_count].number_value = val;
        step_tokens[step_count].overflow     = ovf;
        step_tokens[step_count].token_line   = line;
        step_tokens[step_count].token_column = col;
        step_tokens[step_count].last         = 1'b0;
        step_count++;
    endtask

    task automatic release_held();
        if (held == HOLD_DOT)
            note(K_INVALID, CH_DOT, 64'd0, 1'b0, held_line, held_col);
        else if (held == HOLD_POUND)
            note(K_INVALID, CH_POUND, 64'd0, 1'b0, held_line, held_col);
        else if (held == HOLD_IDENT)
            note(K_IDENT, 8'd0, 64'd0, 1'b0, held_line, held_col);
        held = HOLD_NONE;
    endtask

    // advances the lexer by one character beat, leaving its tokens in step_tokens
    task automatic lex_beat(input logic [7:0] c, input logic eot);
        logic [63:0] digit;
        digit = 64'(c - CH_ZERO);
        step_count = 0;
        if (mode == SCAN_NLSEEN) begin
            mode = SCAN_IDLE;
            if (!eot && is_newline(c))
                return;
        end
        if (!eot)
            col_count = bump(col_count);

        case (mode)
            SCAN_COMMENT: begin
                if (!eot && !is_newline(c))
                    return;
                mode = SCAN_IDLE;
            end
            SCAN_NUMBER, SCAN_LITERAL: begin
                if (!eot && is_digit(c)) begin
                    if (acc > (64'hFFFF_FFFF_FFFF_FFFF - digit) / 64'd10) begin
                        acc = 64'hFFFF_FFFF_FFFF_FFFF;
                        saturated = 1'b1;
                    end else begin
                        acc = acc * 64'd10 + digit;
                    end
                    return;
                end
                note((mode == SCAN_NUMBER) ? K_NUMBER : K_LITERAL, 8'd0, acc, saturated,
                     held_line, held_col);
                mode = SCAN_IDLE;
            end
            SCAN_IDENT, SCAN_SPEC: begin
                if (!eot && !is_blank(c) && !is_newline(c)) begin
                    note(K_TEXT, c, 64'd0, 1'b0, line_count, col_count);
                    return;
                end
                if (mode == SCAN_IDENT)
                    held = HOLD_IDENT;
                else
                    note(K_SPEC, 8'd0, 64'd0, 1'b0, held_line, held_col);
                mode = SCAN_IDLE;
            end
            default: begin
                mode = SCAN_IDLE;
            end
        endcase

        if (eot) begin
            release_held();
            note(K_EOF, 8'd0, 64'd0, 1'b0, line_count, col_count);
        end else if (!is_blank(c)) begin
            if (held == HOLD_IDENT && c == CH_COLON) begin
                note(K_LABEL, 8'd0, 64'd0, 1'b0, held_line, held_col);
                held = HOLD_NONE;
            end else if (held == HOLD_DOT && is_letter(c)) begin
                held = HOLD_NONE;
                mode = SCAN_SPEC;
                note(K_TEXT, c, 64'd0, 1'b0, line_count, col_count);
            end else if (held == HOLD_POUND && is_digit(c)) begin
                held = HOLD_NONE;
                mode = SCAN_LITERAL;
                acc = digit;
                saturated = 1'b0;
            end else begin
                release_held();
                if (is_newline(c)) begin
                    note(K_NEWLINE, 8'd0, 64'd0, 1'b0, line_count, col_count);
                    line_count = bump(line_count);
                    col_count = 16'd0;
                    mode = SCAN_NLSEEN;
                end else if (c == CH_OPEN) begin
                    note(K_OPEN, 8'd0, 64'd0, 1'b0, line_count, col_count);
                end else if (c == CH_CLOSE) begin
                    note(K_CLOSE, 8'd0, 64'd0, 1'b0, line_count, col_count);
                end else if (c == CH_DOT || c == CH_POUND) begin
                    held = (c == CH_DOT) ? HOLD_DOT : HOLD_POUND;
                    held_line = line_count;
                    held_col = col_count;
                end else if (c == CH_SEMI) begin
                    mode = SCAN_COMMENT;
                end else if (is_digit(c)) begin
                    mode = SCAN_NUMBER;
                    acc = digit;
                    saturated = 1'b0;
                    held_line = line_count;
                    held_col = col_count;
                end else if (is_letter(c)) begin
                    mode = SCAN_IDENT;
                    held_line = line_count;
                    held_col = col_count;
                    note(K_TEXT, c, 64'd0, 1'b0, line_count, col_count);
                end else begin
                    note(K_INVALID, c, 64'd0, 1'b0, line_count, col_count);
                end
            end
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = SCAN_IDLE;
            held = HOLD_NONE;
            acc = 64'd0;
            saturated = 1'b0;
            held_line = 16'd0;
            held_col = 16'd0;
            line_count = 16'd0;
            col_count = 16'd0;
            mismatches = 0;
            expected_tokens.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                lex_beat(i_s_tdata, i_s_tuser);
                for (k = 0; k < step_count; k++) begin
                    tok = step_tokens[k];
                    tok.last = (k == step_count - 1);
                    expected_tokens.insert(expected_tokens.size(), tok);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no beat, got kind %0d tdata %0h", $time,
                             i_m_tuser, i_m_tdata);
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("kind", want.kind, i_m_tuser);
                    check_field("text_char", want.text_char, i_m_tdata[7:0]);
                    check_field("number_value", want.number_value, i_m_tdata[71:8]);
                    check_field("overflow", want.overflow, i_m_tdata[72]);
                    check_field("token_line", want.token_line, i_m_tdata[88:73]);
                    check_field("token_column", want.token_column, i_m_tdata[104:89]);
                    check_field("tdata padding", 64'd0, i_m_tdata[111:105]);
                    check_field("tlast", want.last, i_m_tlast);
                end
            end
        end
        o_outstanding = expected_tokens.size();
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_BEATS   = 90;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_POUND = "#";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_OPEN  = "[";
    localparam logic [7:0] CH_CLOSE = "]";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_LO_A  = "a";

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    int  fail_count;
    int  tokens_due;
    int  beats_sent;
    int  stall_cycles;
    bit  calm;
    bit  hold_sink;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    assembly_token_lexer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    lexer_token_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_errors      (fail_count),
        .o_outstanding (tokens_due)
    );

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_letter();
        logic [7:0] off;
        off = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + off;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return 8'd9;
            1: return 8'd11;
            2: return 8'd12;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] c, input logic eot);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_beat(txt[i], 1'b0);
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_beat(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_ident();
        send_beat(pick_letter(), 1'b0);
        repeat ($urandom_range(0, 5)) send_beat(8'($urandom_range(33, 255)), 1'b0);
    endtask

    task automatic send_fragment();
        case ($urandom_range(0, 13))
            0, 1: send_ident();
            2: begin
                send_ident();
                repeat ($urandom_range(0, 2)) send_beat(pick_blank(), 1'b0);
                send_beat(CH_COLON, 1'b0);
            end
            3: begin
                send_beat(CH_DOT, 1'b0);
                send_ident();
            end
            4, 5: send_digits(($urandom_range(0, 5) == 0) ? $urandom_range(19, 22)
                                                          : $urandom_range(1, 6));
            6: begin
                send_beat(CH_POUND, 1'b0);
                send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(19, 21)
                                                        : $urandom_range(1, 4));
            end
            7: send_beat($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE, 1'b0);
            8: begin
                send_beat(CH_SEMI, 1'b0);
                repeat ($urandom_range(0, 4)) send_beat(8'($urandom_range(0, 255)), 1'b0);
                send_beat($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
            end
            9: repeat ($urandom_range(1, 2))
                send_beat($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
            10: send_beat(pick_blank(), 1'b0);
            11: send_beat(8'($urandom_range(0, 255)), 1'b0);
            12: begin
                // broken sequences: stray '.' or '#', lone colon
                case ($urandom_range(0, 2))
                    0: send_beat(CH_DOT, 1'b0);
                    1: send_beat(CH_POUND, 1'b0);
                    default: send_beat(CH_COLON, 1'b0);
                endcase
                send_beat(8'($urandom_range(0, 255)), 1'b0);
            end
            default: repeat ($urandom_range(1, 2))
                send_beat(8'($urandom_range(0, 255)), 1'b1);
        endcase
        if ($urandom_range(0, 1))
            send_beat(pick_blank(), 1'b0);
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
    endtask

    initial begin
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            int gap;
            if (hold_sink) begin
                hold_sink = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = calm ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = 1'b0;
        calm       = 1'b0;
        hold_sink  = 1'b0;
        beats_sent = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // label, specifier, literal, brackets, comment with merged CR LF
        send_text("Ab :");
        send_text(".q ");
        send_text("#7 ");
        send_text("[]");
        send_text(";x");
        send_beat(CH_CR, 1'b0);
        send_beat(CH_LF, 1'b0);
        // lone colon, unmatched dot before a number, bytes outside every class
        send_text(":.5");
        send_beat(CH_LF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        // unmatched pound before a letter, then end of text twice
        send_text("#a");
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        send_beat(8'($urandom_range(0, 255)), 1'b1);

        hold_sink = 1'b1;
        while (beats_sent < 30 + RANDOM_BEATS)
            send_fragment();

        send_text("[k");
        send_beat(8'd0, 1'b1);
        s_tvalid <= 1'b0;

        while (tokens_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
sv/atl_pkg.sv
sv/atl_beat_fifo.sv
sv/assembly_token_lexer.sv
test/lexer_token_checker.sv
test/testbench.sv
